// ===== rtl/core/aesp_pkg.sv =====
// Shared types, constants and helper functions of the escape sequence parser.
package aesp_pkg;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int NUM_W  = 16;
    localparam int ATTR_W = 16;
    localparam int KIND_W = 4;

    // Special bytes
    localparam logic [BYTE_W-1:0] ESC_CHAR   = 8'd27;
    localparam logic [BYTE_W-1:0] CHAR_LBRK  = 8'h5B; // '['
    localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B; // ';'
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30; // '0'
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39; // '9'
    localparam logic [BYTE_W-1:0] CHAR_LC_S  = 8'h73; // 's'
    localparam logic [BYTE_W-1:0] CHAR_LC_U  = 8'h75; // 'u'
    localparam logic [BYTE_W-1:0] CHAR_LC_F  = 8'h66; // 'f'
    localparam logic [BYTE_W-1:0] CHAR_LC_M  = 8'h6D; // 'm'
    localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41; // 'A'
    localparam logic [BYTE_W-1:0] CHAR_UC_B  = 8'h42; // 'B'
    localparam logic [BYTE_W-1:0] CHAR_UC_C  = 8'h43; // 'C'
    localparam logic [BYTE_W-1:0] CHAR_UC_D  = 8'h44; // 'D'
    localparam logic [BYTE_W-1:0] CHAR_UC_H  = 8'h48; // 'H'
    localparam logic [BYTE_W-1:0] CHAR_UC_J  = 8'h4A; // 'J'

    // Number accumulation wraps modulo this value
    localparam logic [NUM_W-1:0] NUM_MOD = 16'hFFFF;
    localparam logic [NUM_W-1:0] NUM_CLEAR_ALL = 16'd2;

    // Attribute constants
    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 16'h0007;
    localparam logic [ATTR_W-1:0] ATTR_BRIGHT  = 16'h0088;
    localparam logic [ATTR_W-1:0] ATTR_ULINE   = 16'h8000;
    localparam logic [ATTR_W-1:0] MASK_FG      = 16'h00F8;
    localparam logic [ATTR_W-1:0] MASK_BG      = 16'h008F;
    localparam logic [ATTR_W-1:0] MASK_FG_DEF  = 16'h00F7;
    localparam logic [ATTR_W-1:0] MASK_BG_DEF  = 16'h007F;

    // Parse phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_V1_START,
        PH_V1_MORE,
        PH_V2_START,
        PH_V2_MORE
    } phase_t;

    // Result kind
    typedef enum logic [KIND_W-1:0] {
        KIND_TEXT    = 4'd0,
        KIND_ATTR    = 4'd1,
        KIND_SAVE    = 4'd2,
        KIND_RESTORE = 4'd3,
        KIND_POS     = 4'd4,
        KIND_UP      = 4'd5,
        KIND_DOWN    = 4'd6,
        KIND_FWD     = 4'd7,
        KIND_BACK    = 4'd8,
        KIND_CLEAR   = 4'd9
    } kind_t;

    // Command handed from the front to the back through the queue.
    // For attribute commands n1/n2 carry the SGR codes.
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] text_byte;
        logic [NUM_W-1:0]  n1;
        logic [NUM_W-1:0]  n2;
        logic              two_codes;
    } cmd_t;

    // (v * 10 + d) mod 65535; v < 65535 so the folded sum needs one correction
    function automatic logic [NUM_W-1:0] accumulate(input logic [NUM_W-1:0] v,
                                                    input logic [3:0] d);
        logic [NUM_W+3:0] x;
        logic [NUM_W:0]   s;
        x = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{NUM_W{1'b0}}, d};
        s = {1'b0, x[NUM_W-1:0]} + {{(NUM_W-3){1'b0}}, x[NUM_W+3:NUM_W]};
        if (s >= {1'b0, NUM_MOD})
            s = s - {1'b0, NUM_MOD};
        return s[NUM_W-1:0];
    endfunction

    // Apply one SGR code to an attribute word
    function automatic logic [ATTR_W-1:0] sgr_apply(input logic [ATTR_W-1:0] a,
                                                    input logic [NUM_W-1:0] code);
        logic [ATTR_W-1:0] r;
        case (code)
            16'd0:   r = ATTR_DEFAULT;
            16'd1:   r = a | ATTR_BRIGHT;
            16'd4:   r = a | ATTR_ULINE;
            16'd7:   r = {8'h00, a[3:0], a[7:4]};
            16'd30:  r = a & MASK_FG;
            16'd31:  r = (a & MASK_FG) | 16'h0004;
            16'd32:  r = (a & MASK_FG) | 16'h0002;
            16'd33:  r = (a & MASK_FG) | 16'h0006;
            16'd34:  r = (a & MASK_FG) | 16'h0001;
            16'd35:  r = (a & MASK_FG) | 16'h0005;
            16'd36:  r = (a & MASK_FG) | 16'h0003;
            16'd37:  r = (a & MASK_FG) | 16'h0007;
            16'd39:  r = a & MASK_FG_DEF;
            16'd40:  r = a & MASK_BG;
            16'd41:  r = (a & MASK_BG) | 16'h0040;
            16'd42:  r = (a & MASK_BG) | 16'h0020;
            16'd43:  r = (a & MASK_BG) | 16'h0060;
            16'd44:  r = (a & MASK_BG) | 16'h0010;
            16'd45:  r = (a & MASK_BG) | 16'h0050;
            16'd46:  r = (a & MASK_BG) | 16'h0030;
            16'd47:  r = (a & MASK_BG) | 16'h0070;
            16'd49:  r = a & MASK_BG_DEF;
            default: r = code;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/aesp_front.sv =====
// Front end: takes input bytes, runs the sequence parser and issues commands.
module aesp_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [aesp_pkg::BYTE_W-1:0] in_byte,
    input  logic                   q_ready,
    output logic                   in_ready,
    output logic                   cmd_valid,
    output aesp_pkg::cmd_t         cmd
);
    import aesp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [NUM_W-1:0]  v1_reg, v1_next;
    logic [NUM_W-1:0]  v2_reg, v2_next;
    logic              accept;
    logic              is_digit;
    logic [3:0]        digit_val;
    logic [NUM_W-1:0]  v1_acc, v2_acc;
    logic              emit;

    assign in_ready  = q_ready;
    assign accept    = in_valid && q_ready;
    assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    assign digit_val = is_digit ? 4'(in_byte - CHAR_ZERO) : 4'd0;
    assign v1_acc    = accumulate(v1_reg, digit_val);
    assign v2_acc    = accumulate(v2_reg, digit_val);
    assign cmd_valid = accept && emit;

    // Next parse phase
    always_comb
    begin
        phase_next = PH_IDLE;
        case (phase_reg)
            PH_IDLE:     if (in_byte == ESC_CHAR) phase_next = PH_ESC;
            PH_ESC:      if (in_byte == CHAR_LBRK) phase_next = PH_V1_START;
            PH_V1_START:
            begin
                if (is_digit)                phase_next = PH_V1_MORE;
                else if (in_byte == CHAR_SEMI) phase_next = PH_V1_START;
            end
            PH_V1_MORE:
            begin
                if (is_digit)                phase_next = PH_V1_MORE;
                else if (in_byte == CHAR_SEMI) phase_next = PH_V2_START;
            end
            PH_V2_START:
            begin
                if (is_digit)                phase_next = PH_V2_MORE;
                else if (in_byte == CHAR_SEMI) phase_next = PH_V2_START;
            end
            PH_V2_MORE:
            begin
                if (is_digit)                phase_next = PH_V2_MORE;
                else if (in_byte == CHAR_SEMI) phase_next = PH_V1_START;
            end
            default:     phase_next = PH_IDLE;
        endcase
    end

    // Number updates and command decode
    always_comb
    begin
        v1_next       = v1_reg;
        v2_next       = v2_reg;
        emit          = 1'b0;
        cmd.kind      = KIND_TEXT;
        cmd.text_byte = '0;
        cmd.n1        = '0;
        cmd.n2        = '0;
        cmd.two_codes = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte == ESC_CHAR)
                begin
                    v1_next = '0;
                    v2_next = '0;
                end
                else
                begin
                    emit          = 1'b1;
                    cmd.text_byte = in_byte;
                end
            end
            PH_V1_START:
            begin
                if (is_digit)
                    v1_next = v1_acc;
                else if (in_byte == CHAR_LC_S)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_SAVE;
                end
                else if (in_byte == CHAR_LC_U)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_RESTORE;
                end
                else if (in_byte == CHAR_UC_H || in_byte == CHAR_LC_F)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_POS;
                end
            end
            PH_V1_MORE:
            begin
                cmd.n1 = v1_reg;
                if (is_digit)
                    v1_next = v1_acc;
                else if (in_byte == CHAR_LC_M)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_ATTR;
                end
                else if (in_byte == CHAR_UC_A)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_UP;
                end
                else if (in_byte == CHAR_UC_B)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_DOWN;
                end
                else if (in_byte == CHAR_UC_C)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_FWD;
                end
                else if (in_byte == CHAR_UC_D)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_BACK;
                end
                else if (in_byte == CHAR_UC_J && v1_reg == NUM_CLEAR_ALL)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_CLEAR;
                    cmd.n1   = '0;
                end
            end
            PH_V2_START:
            begin
                if (is_digit)
                    v2_next = v2_acc;
            end
            PH_V2_MORE:
            begin
                cmd.n1 = v1_reg;
                cmd.n2 = v2_reg;
                if (is_digit)
                    v2_next = v2_acc;
                else if (in_byte == CHAR_LC_M || in_byte == CHAR_SEMI)
                begin
                    emit          = 1'b1;
                    cmd.kind      = KIND_ATTR;
                    cmd.two_codes = 1'b1;
                    if (in_byte == CHAR_SEMI)
                    begin
                        v1_next = '0;
                        v2_next = '0;
                    end
                end
                else if (in_byte == CHAR_UC_H || in_byte == CHAR_LC_F)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_POS;
                end
            end
            default: ;
        endcase
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            v1_reg    <= '0;
            v2_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
        end
    end

endmodule

// ===== rtl/core/aesp_queue.sv =====
// Small command queue between the parser front and the execution back end.
module aesp_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  aesp_pkg::cmd_t push_data,
    output logic           push_ready,
    output logic           pop_valid,
    input  logic           pop_ready,
    output aesp_pkg::cmd_t pop_data
);
    import aesp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/aesp_back.sv =====
// Back end: executes commands, keeps the text attribute, drives the output register.
module aesp_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [aesp_pkg::ATTR_W-1:0]  cfg_wdata,
    input  logic                         q_valid,
    input  aesp_pkg::cmd_t               q_data,
    output logic                         q_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [aesp_pkg::KIND_W-1:0]  out_kind,
    output logic [aesp_pkg::BYTE_W-1:0]  out_text,
    output logic [aesp_pkg::NUM_W-1:0]   out_n1,
    output logic [aesp_pkg::NUM_W-1:0]   out_n2,
    output logic [aesp_pkg::ATTR_W-1:0]  out_attr
);
    import aesp_pkg::*;

    logic              valid_reg, valid_next;
    logic [ATTR_W-1:0] cur_attr_reg, cur_attr_next;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] text_reg;
    logic [NUM_W-1:0]  n1_reg, n2_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic [ATTR_W-1:0] attr_one, attr_two, attr_new;
    logic              take;
    logic              is_attr;

    assign q_ready = !valid_reg || out_ready;
    assign take    = q_valid && q_ready;
    assign is_attr = (q_data.kind == KIND_ATTR);

    // SGR codes applied in order
    assign attr_one = sgr_apply(cur_attr_reg, q_data.n1);
    assign attr_two = sgr_apply(attr_one, q_data.n2);
    assign attr_new = q_data.two_codes ? attr_two : attr_one;

    always_comb
    begin
        valid_next    = valid_reg;
        cur_attr_next = cur_attr_reg;
        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        if (cfg_we)
            cur_attr_next = cfg_wdata;
        else if (take && is_attr)
            cur_attr_next = attr_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            cur_attr_reg <= ATTR_DEFAULT;
        end
        else
        begin
            valid_reg    <= valid_next;
            cur_attr_reg <= cur_attr_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= q_data.kind;
            text_reg <= q_data.text_byte;
            n1_reg   <= is_attr ? '0 : q_data.n1;
            n2_reg   <= is_attr ? '0 : q_data.n2;
            attr_reg <= is_attr ? attr_new : '0;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_text  = text_reg;
    assign out_n1    = n1_reg;
    assign out_n2    = n2_reg;
    assign out_attr  = attr_reg;

endmodule

// ===== rtl/core/ansi_escape_sequence_parser_unit.sv =====
// Top level of the escape sequence parser: front, command queue and back end.
//
//  Channel   Dir  Payload                                           Handshake
//  s_axis    in   tdata[7:0] byte_in                                tvalid/tready
//  m_axis    out  tuser[3:0] kind; tdata text_byte, first_number,   tvalid/tready
//                 second_number, attribute
//  cfg       in   cfg_wdata[15:0] initial_attribute                 cfg_we
//
// One byte is taken every cycle while the queue has room; a result is registered
// first into the queue, then into the back end output register.
// The queue of QUEUE_DEPTH commands lets the parser keep taking bytes while a
// result waits on m_axis_tready; s_axis_tready drops only when the queue is full.
// Reset puts the parser outside any sequence, empties the queue and sets the
// kept attribute to 7. A configuration write loads the kept attribute only.
module ansi_escape_sequence_parser_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [7:0] text_byte, [23:8] first_number,
                                        // [39:24] second_number, [55:40] attribute
    output logic [3:0]  m_axis_tuser,   // [3:0] kind
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata       // [15:0] initial_attribute
);
    import aesp_pkg::*;

    cmd_t              f_cmd, q_cmd;
    logic              f_valid, q_push_ready, q_valid, q_pop_ready;
    logic [KIND_W-1:0] o_kind;
    logic [BYTE_W-1:0] o_text;
    logic [NUM_W-1:0]  o_n1, o_n2;
    logic [ATTR_W-1:0] o_attr;

    aesp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .q_ready   (q_push_ready),
        .in_ready  (s_axis_tready),
        .cmd_valid (f_valid),
        .cmd       (f_cmd)
    );

    aesp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_data  (f_cmd),
        .push_ready (q_push_ready),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_cmd)
    );

    aesp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_data    (q_cmd),
        .q_ready   (q_pop_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (o_kind),
        .out_text  (o_text),
        .out_n1    (o_n1),
        .out_n2    (o_n2),
        .out_attr  (o_attr)
    );

    assign m_axis_tuser = o_kind;
    assign m_axis_tdata = {o_attr, o_n2, o_n1, o_text};

endmodule

// ===== dv/tb_ansi_escape_sequence_parser_unit.sv =====
// Self-checking testbench for the escape sequence parser: byte stream in, display commands out.
`timescale 1ns / 1ps

module tb_ansi_escape_sequence_parser_unit;
    import aesp_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_WAIT  = 6;
    localparam int PHASE_ITEMS  = 360;
    localparam logic [7:0] CHAR_UC_K = 8'h4B; // 'K', erase line

    // One display command as the block reports it
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  text_byte;
        logic [15:0] first_number;
        logic [15:0] second_number;
        logic [15:0] attribute;
    } display_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    // Bytes waiting to be offered and commands waiting to come out
    logic [7:0]   outbound_bytes[$];
    display_cmd_t due_cmds[$];

    // Parser state as the predictor sees it
    phase_t      parse_state = PH_IDLE;
    logic [15:0] num_first = 16'h0000;
    logic [15:0] num_second = 16'h0000;
    logic [15:0] kept_attr = ATTR_DEFAULT;

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    logic hold_off = 1'b0;
    bit  stall_request = 1'b0;
    int  error_count = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;

    int sgr_codes[22] = '{0, 1, 4, 7, 30, 31, 32, 33, 34, 35, 36, 37, 39,
                          40, 41, 42, 43, 44, 45, 46, 47, 49};

    ansi_escape_sequence_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decimal digit folded into a number, wrapping modulo 65535
    function automatic logic [15:0] next_value(input logic [15:0] v, input int unsigned d);
        int unsigned acc;
        acc = (int'(v) * 10 + d) % 65535;
        return acc[15:0];
    endfunction

    // SGR code applied to an attribute word; ANSI color index has red in bit 0,
    // the console word has red in bit 2, so the three bits are reversed
    function automatic logic [15:0] apply_sgr(input logic [15:0] a, input logic [15:0] code);
        int unsigned idx;
        logic [2:0] hue;
        idx = code % 10;
        hue = {idx[0], idx[1], idx[2]};
        if (code == 0)
            return 16'h0007;
        else if (code == 1)
            return a | 16'h0088;
        else if (code == 4)
            return a | 16'h8000;
        else if (code == 7)
            return {8'h00, a[3:0], a[7:4]};
        else if (code >= 30 && code <= 37)
            return (a & 16'h00F8) | {13'd0, hue};
        else if (code == 39)
            return a & 16'h00F7;
        else if (code >= 40 && code <= 47)
            return (a & 16'h008F) | {9'd0, hue, 4'd0};
        else if (code == 49)
            return a & 16'h007F;
        return code;
    endfunction

    // Advance the predicted parser by one byte and queue any command it makes
    function automatic void parse_byte(input logic [7:0] b);
        logic        is_digit;
        int unsigned dv;
        phase_t      was;
        display_cmd_t r;
        bit          hit;
        is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        dv = is_digit ? int'(b - CHAR_ZERO) : 0;
        r = '0;
        hit = 1'b0;
        was = parse_state;
        parse_state = PH_IDLE;
        case (was)
            PH_IDLE:
            begin
                if (b == ESC_CHAR)
                begin
                    parse_state = PH_ESC;
                    num_first = 16'h0000;
                    num_second = 16'h0000;
                end
                else
                begin
                    hit = 1'b1;
                    r.kind = KIND_TEXT;
                    r.text_byte = b;
                end
            end
            PH_ESC:
            begin
                if (b == CHAR_LBRK)
                    parse_state = PH_V1_START;
            end
            PH_V1_START:
            begin
                if (is_digit)
                begin
                    num_first = next_value(num_first, dv);
                    parse_state = PH_V1_MORE;
                end
                else if (b == CHAR_SEMI)
                    parse_state = PH_V1_START;
                else if (b == CHAR_LC_S)
                begin
                    hit = 1'b1;
                    r.kind = KIND_SAVE;
                end
                else if (b == CHAR_LC_U)
                begin
                    hit = 1'b1;
                    r.kind = KIND_RESTORE;
                end
                else if (b == CHAR_UC_H || b == CHAR_LC_F)
                begin
                    hit = 1'b1;
                    r.kind = KIND_POS;
                end
            end
            PH_V1_MORE:
            begin
                hit = 1'b1;
                r.first_number = num_first;
                if (is_digit)
                begin
                    hit = 1'b0;
                    num_first = next_value(num_first, dv);
                    parse_state = PH_V1_MORE;
                end
                else if (b == CHAR_SEMI)
                begin
                    hit = 1'b0;
                    parse_state = PH_V2_START;
                end
                else if (b == CHAR_LC_M)
                begin
                    kept_attr = apply_sgr(kept_attr, num_first);
                    r = '0;
                    r.kind = KIND_ATTR;
                    r.attribute = kept_attr;
                end
                else if (b == CHAR_UC_A)
                    r.kind = KIND_UP;
                else if (b == CHAR_UC_B)
                    r.kind = KIND_DOWN;
                else if (b == CHAR_UC_C)
                    r.kind = KIND_FWD;
                else if (b == CHAR_UC_D)
                    r.kind = KIND_BACK;
                else if (b == CHAR_UC_J && num_first == NUM_CLEAR_ALL)
                begin
                    r = '0;
                    r.kind = KIND_CLEAR;
                end
                else
                    hit = 1'b0;
            end
            PH_V2_START:
            begin
                if (is_digit)
                begin
                    num_second = next_value(num_second, dv);
                    parse_state = PH_V2_MORE;
                end
                else if (b == CHAR_SEMI)
                    parse_state = PH_V2_START;
            end
            PH_V2_MORE:
            begin
                if (is_digit)
                begin
                    num_second = next_value(num_second, dv);
                    parse_state = PH_V2_MORE;
                end
                else if (b == CHAR_LC_M || b == CHAR_SEMI)
                begin
                    kept_attr = apply_sgr(kept_attr, num_first);
                    kept_attr = apply_sgr(kept_attr, num_second);
                    if (b == CHAR_SEMI)
                    begin
                        num_first = 16'h0000;
                        num_second = 16'h0000;
                        parse_state = PH_V1_START;
                    end
                    hit = 1'b1;
                    r.kind = KIND_ATTR;
                    r.attribute = kept_attr;
                end
                else if (b == CHAR_UC_H || b == CHAR_LC_F)
                begin
                    hit = 1'b1;
                    r.kind = KIND_POS;
                    r.first_number = num_first;
                    r.second_number = num_second;
                end
            end
            default:
            begin
            end
        endcase
        if (hit)
            due_cmds.push_back(r);
    endfunction

    // Stimulus helpers
    task automatic push_str(input string txt);
        int k;
        for (k = 0; k < txt.len(); k++)
            outbound_bytes.push_back(txt[k]);
    endtask

    task automatic push_number();
        int sel;
        int n;
        int k;
        int unsigned v;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            v = sgr_codes[$urandom_range(0, $size(sgr_codes) - 1)];
        else if (sel < 7)
            v = $urandom_range(0, 99);
        else if (sel < 8)
            v = $urandom_range(0, 65535);
        else if (sel < 9)
            v = 65534 + $urandom_range(0, 1);
        if (sel < 9)
            push_str($sformatf("%0d", v));
        else
        begin
            // long digit run, leading zeros allowed, wraps the accumulator
            n = $urandom_range(5, 9);
            for (k = 0; k < n; k++)
                outbound_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic push_text_byte();
        int b;
        b = $urandom_range(0, 254);
        if (b >= ESC_CHAR)
            b = b + 1;
        outbound_bytes.push_back(b[7:0]);
    endtask

    // One random sequence: mostly well-formed commands, some noise
    task automatic add_random_sequence();
        int sel;
        int k;
        int n;
        string finals;
        finals = "mABCDJHKfsu";
        sel = $urandom_range(0, 99);
        if (sel < 20)
        begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                push_text_byte();
        end
        else if (sel < 30)
        begin
            outbound_bytes.push_back(ESC_CHAR);
            outbound_bytes.push_back(CHAR_LBRK);
            push_str(finals.substr($urandom_range(5, 10), $urandom_range(5, 10)));
            if (outbound_bytes[$] == CHAR_LBRK)
                outbound_bytes.push_back(CHAR_LC_S);
        end
        else if (sel < 55)
        begin
            outbound_bytes.push_back(ESC_CHAR);
            outbound_bytes.push_back(CHAR_LBRK);
            if ($urandom_range(0, 7) == 0)
                push_str("2J");
            else
            begin
                push_number();
                outbound_bytes.push_back(finals[$urandom_range(0, finals.len() - 1)]);
            end
        end
        else if (sel < 75)
        begin
            outbound_bytes.push_back(ESC_CHAR);
            outbound_bytes.push_back(CHAR_LBRK);
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
            begin
                // chained code pairs, each pair closed by a semicolon
                push_number();
                outbound_bytes.push_back(CHAR_SEMI);
                push_number();
                outbound_bytes.push_back(CHAR_SEMI);
            end
            push_number();
            outbound_bytes.push_back(CHAR_SEMI);
            push_number();
            case ($urandom_range(0, 3))
                0: outbound_bytes.push_back(CHAR_UC_H);
                1: outbound_bytes.push_back(CHAR_LC_F);
                default: outbound_bytes.push_back(CHAR_LC_M);
            endcase
        end
        else if (sel < 82)
        begin
            // leading and doubled semicolons
            outbound_bytes.push_back(ESC_CHAR);
            outbound_bytes.push_back(CHAR_LBRK);
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
                outbound_bytes.push_back(CHAR_SEMI);
            push_number();
            n = $urandom_range(1, 2);
            for (k = 0; k < n; k++)
                outbound_bytes.push_back(CHAR_SEMI);
            push_number();
            outbound_bytes.push_back(finals[$urandom_range(0, 1)]);
        end
        else
        begin
            // broken sequences and raw bytes
            outbound_bytes.push_back(ESC_CHAR);
            case ($urandom_range(0, 4))
                0:
                    outbound_bytes.push_back(8'($urandom_range(0, 255)));
                1:
                begin
                    outbound_bytes.push_back(CHAR_LBRK);
                    push_number();
                    outbound_bytes.push_back(8'($urandom_range(0, 255)));
                end
                2:
                begin
                    outbound_bytes.push_back(CHAR_LBRK);
                    push_number();
                    outbound_bytes.push_back(CHAR_SEMI);
                    if ($urandom_range(0, 1))
                        push_number();
                    outbound_bytes.push_back(8'($urandom_range(0, 255)));
                end
                3:
                begin
                    outbound_bytes.push_back(CHAR_LBRK);
                    outbound_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                        outbound_bytes.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // Wait until every byte is taken and every command has come out
    task automatic settle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (outbound_bytes.size() != 0 || s_axis_tvalid || due_cmds.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_attr(input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        kept_attr = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        error_count++;
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 results_seen, what, want, got);
    endtask

    // Byte sender: keeps an item up until taken, predicts on acceptance
    always @(posedge clk)
    begin : byte_driver
        logic       nv;
        logic [7:0] nd;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata);
            nv = s_axis_tvalid && !s_axis_tready;
            nd = s_axis_tdata;
            if (!nv && outbound_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                nv = 1'b1;
                nd = outbound_bytes.pop_front();
            end
            s_axis_tvalid <= nv;
            s_axis_tdata <= nd;
        end
    end

    // Result receiver with random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Long receiver hold-off so the internal queue fills and input stalls
    initial
    begin
        wait (stall_request);
        repeat (20) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Result checker
    always @(posedge clk)
    begin : cmd_monitor
        display_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (due_cmds.size() == 0)
                report_mismatch("result with none due", 16'h0000, {12'd0, m_axis_tuser});
            else
            begin
                want = due_cmds.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", {12'd0, want.kind}, {12'd0, m_axis_tuser});
                if (m_axis_tdata[7:0] !== want.text_byte)
                    report_mismatch("text_byte", {8'd0, want.text_byte},
                                    {8'd0, m_axis_tdata[7:0]});
                if (m_axis_tdata[23:8] !== want.first_number)
                    report_mismatch("first_number", want.first_number, m_axis_tdata[23:8]);
                if (m_axis_tdata[39:24] !== want.second_number)
                    report_mismatch("second_number", want.second_number, m_axis_tdata[39:24]);
                if (m_axis_tdata[55:40] !== want.attribute)
                    report_mismatch("attribute", want.attribute, m_axis_tdata[55:40]);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[ansi_escape_sequence_parser_unit] ERROR");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: text extremes, ESC without bracket, home, clear, erase,
        // two codes closed by a semicolon, unknown SGR code
        outbound_bytes.push_back(8'h00);
        outbound_bytes.push_back(8'hFF);
        outbound_bytes.push_back(ESC_CHAR);
        push_str("x");
        outbound_bytes.push_back(ESC_CHAR);
        push_str("[H");
        outbound_bytes.push_back(ESC_CHAR);
        push_str("[2J");
        outbound_bytes.push_back(ESC_CHAR);
        push_str("[J");
        outbound_bytes.push_back(ESC_CHAR);
        push_str("[1;4;7m");
        outbound_bytes.push_back(ESC_CHAR);
        push_str("[99m");
        settle();

        // Sender idles lightly, receiver heavily
        write_attr(16'h0000);
        src_idle_pct = 14;
        snk_idle_pct = 48;
        while (outbound_bytes.size() < PHASE_ITEMS)
            add_random_sequence();
        settle();

        // Receiver idles lightly, sender heavily, with one long hold-off
        write_attr(16'hFFFF);
        src_idle_pct = 48;
        snk_idle_pct = 14;
        while (outbound_bytes.size() < PHASE_ITEMS)
            add_random_sequence();
        stall_request = 1'b1;
        settle();

        // Full rate on both sides
        write_attr(16'($urandom_range(0, 65535)));
        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (outbound_bytes.size() < PHASE_ITEMS)
            add_random_sequence();
        settle();

        if (error_count == 0)
            $display("[ansi_escape_sequence_parser_unit] OK");
        else
            $display("[ansi_escape_sequence_parser_unit] ERROR");
        $finish;
    end

endmodule
